// ----- src/sdtq_pkg.sv -----
package sdtq_pkg;

  typedef enum logic [1:0] {
    RK_INSERT = 2'd0,
    RK_CANCEL = 2'd1,
    RK_WOKEN  = 2'd2,
    RK_DONE   = 2'd3
  } rkind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // One queue slot: absolute deadline and the sleeping thread
  typedef struct packed {
    logic [63:0] deadline;
    logic [15:0] thread;
  } entry_t;

  // One result item as it leaves the block
  typedef struct packed {
    rkind_t      result_kind;
    status_t     status;
    logic [15:0] woken_thread;
    logic        is_earliest;
    logic        pending;
    logic [31:0] next_delay;
    logic        last;
  } res_t;

endpackage

// ----- src/sdtq_if.sv -----
interface sdtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] tid;
  logic [31:0] amount;
  logic [63:0] now;

  modport source (output valid, output kind, output tid, output amount, output now,
                  input ready);
  modport sink (input valid, input kind, input tid, input amount, input now,
                output ready);
endinterface

interface sdtq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  status;
  logic [15:0] woken_thread;
  logic        is_earliest;
  logic        pending;
  logic [31:0] next_delay;
  logic        last;

  modport source (output valid, output result_kind, output status, output woken_thread,
                  output is_earliest, output pending, output next_delay, output last,
                  input ready);
  modport sink (input valid, input result_kind, input status, input woken_thread,
                input is_earliest, input pending, input next_delay, input last,
                output ready);
endinterface

// ----- src/sdtq_store.sv -----
module sdtq_store #(
  parameter int DEPTH = 16,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  sdtq_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output sdtq_pkg::entry_t    rdata
);
  import sdtq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sdtq_out_reg.sv -----
module sdtq_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sdtq_pkg::res_t  data,
  output logic            free,
  sdtq_out_if.source      out_ch
);
  import sdtq_pkg::*;

  logic valid_r;
  res_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.result_kind  = data_r.result_kind;
  assign out_ch.status       = data_r.status;
  assign out_ch.woken_thread = data_r.woken_thread;
  assign out_ch.is_earliest  = data_r.is_earliest;
  assign out_ch.pending      = data_r.pending;
  assign out_ch.next_delay   = data_r.next_delay;
  assign out_ch.last         = data_r.last;

endmodule

// ----- src/sdtq_seq.sv -----
module sdtq_seq #(
  parameter int MAX_ENTRIES = 16,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  sdtq_in_if.sink             in_ch,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output sdtq_pkg::entry_t    mem_wdata,
  output logic                mem_re,
  output logic [IDX_W-1:0]    mem_raddr,
  input  sdtq_pkg::entry_t    mem_rdata,
  output logic                emit_valid,
  output sdtq_pkg::res_t      emit_data,
  input  logic                out_free
);
  import sdtq_pkg::*;

  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [1:0] {
    KIND_SLEEP  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } op_kind_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SHDN  = 7'b0000100,
    S_SHUP  = 7'b0001000,
    S_TKRD  = 7'b0010000,
    S_TKCMP = 7'b0100000,
    S_ACK   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               is_ins_r, is_ins_nxt;
  logic [15:0]        tid_r, tid_nxt;
  logic [63:0]        now_r, now_nxt;
  logic [63:0]        dl_r, dl_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [CNT_W-1:0]   wr_dst_r, wr_dst_nxt;
  logic               match_r, match_nxt;
  logic [CNT_W-1:0]   match_pos_r, match_pos_nxt;
  logic               gt_r, gt_nxt;
  logic [CNT_W-1:0]   gt_pos_r, gt_pos_nxt;
  res_t               ack_r, ack_nxt;
  logic [CNT_W-1:0]   ins_pos;

  // Map a position in deadline order to a slot of the circular store
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                            input logic [CNT_W-1:0] l);
    logic [SUM_W-1:0] s;
    s = SUM_W'(hd) + SUM_W'(l);
    if (s >= SUM_W'(MAX_ENTRIES)) begin
      s = s - SUM_W'(MAX_ENTRIES);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic res_t mk_res(input rkind_t rk, input status_t st,
                                  input logic [15:0] thr, input logic earliest,
                                  input logic pend, input logic [31:0] delay,
                                  input logic lst);
    res_t r;
    r.result_kind  = rk;
    r.status       = st;
    r.woken_thread = thr;
    r.is_earliest  = earliest;
    r.pending      = pend;
    r.next_delay   = delay;
    r.last         = lst;
    return r;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign ins_pos     = gt_r ? gt_pos_r : count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    is_ins_nxt    = is_ins_r;
    tid_nxt       = tid_r;
    now_nxt       = now_r;
    dl_nxt        = dl_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    wr_pend_nxt   = wr_pend_r;
    wr_dst_nxt    = wr_dst_r;
    match_nxt     = match_r;
    match_pos_nxt = match_pos_r;
    gt_nxt        = gt_r;
    gt_pos_nxt    = gt_pos_r;
    ack_nxt       = ack_r;
    mem_we        = 1'b0;
    mem_waddr     = phys(head_r, wr_dst_r);
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = head_r;
    emit_valid    = 1'b0;
    emit_data     = ack_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tid_nxt     = in_ch.tid;
          now_nxt     = in_ch.now;
          dl_nxt      = in_ch.now + 64'(in_ch.amount) + 64'd1;
          idx_nxt     = '0;
          rd_vld_nxt  = 1'b0;
          match_nxt   = 1'b0;
          gt_nxt      = 1'b0;
          wr_pend_nxt = 1'b0;
          unique case (in_ch.kind)
            KIND_SLEEP: begin
              is_ins_nxt = 1'b1;
              if (in_ch.amount == 32'd0) begin
                ack_nxt   = mk_res(RK_INSERT, ST_ZERO, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
                state_nxt = S_ACK;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_CANCEL: begin
              is_ins_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
            KIND_TICK: begin
              state_nxt = S_TKRD;
            end
            default: begin
              // drop the unused kind
            end
          endcase
        end
      end

      S_SCAN: begin
        // check the slot read last cycle
        if (rd_vld_r) begin
          if (mem_rdata.thread == tid_r && !match_r) begin
            match_nxt     = 1'b1;
            match_pos_nxt = rd_idx_r;
          end
          if (mem_rdata.deadline > dl_r && !gt_r) begin
            gt_nxt     = 1'b1;
            gt_pos_nxt = rd_idx_r;
          end
        end
        if (idx_r < count_r) begin
          mem_re     = 1'b1;
          mem_raddr  = phys(head_r, idx_r);
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            if (is_ins_r) begin
              if (match_r) begin
                ack_nxt   = mk_res(RK_INSERT, ST_MISS, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
                state_nxt = S_ACK;
              end else if (count_r == CNT_W'(MAX_ENTRIES)) begin
                ack_nxt   = mk_res(RK_INSERT, ST_FULL, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
                state_nxt = S_ACK;
              end else begin
                ack_nxt   = mk_res(RK_INSERT, ST_OK, 16'd0, ins_pos == '0, 1'b0, 32'd0,
                                   1'b1);
                pos_nxt   = ins_pos;
                idx_nxt   = count_r;
                state_nxt = S_SHDN;
              end
            end else begin
              if (match_r) begin
                ack_nxt   = mk_res(RK_CANCEL, ST_OK, tid_r, 1'b0, 1'b0, 32'd0, 1'b1);
                idx_nxt   = match_pos_r;
                state_nxt = S_SHUP;
              end else begin
                ack_nxt   = mk_res(RK_CANCEL, ST_MISS, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
                state_nxt = S_ACK;
              end
            end
          end
        end
      end

      S_SHDN: begin
        // move entries one slot toward the tail, then drop in the new one
        if (wr_pend_r) begin
          mem_we = 1'b1;
        end
        if (idx_r > pos_r) begin
          mem_re      = 1'b1;
          mem_raddr   = phys(head_r, idx_r - 1'b1);
          wr_pend_nxt = 1'b1;
          wr_dst_nxt  = idx_r;
          idx_nxt     = idx_r - 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            mem_we    = 1'b1;
            mem_waddr = phys(head_r, pos_r);
            mem_wdata = '{deadline: dl_r, thread: tid_r};
            count_nxt = count_r + 1'b1;
            state_nxt = S_ACK;
          end
        end
      end

      S_SHUP: begin
        // close the gap left by the cancelled entry
        if (wr_pend_r) begin
          mem_we = 1'b1;
        end
        if ((CNT_W + 1)'(idx_r) + 1'b1 < (CNT_W + 1)'(count_r)) begin
          mem_re      = 1'b1;
          mem_raddr   = phys(head_r, idx_r + 1'b1);
          wr_pend_nxt = 1'b1;
          wr_dst_nxt  = idx_r;
          idx_nxt     = idx_r + 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_ACK;
          end
        end
      end

      S_TKRD: begin
        if (count_r == '0) begin
          emit_data = mk_res(RK_DONE, ST_OK, 16'd0, 1'b0, 1'b0, 32'd0, 1'b1);
          if (out_free) begin
            emit_valid = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_r;
          state_nxt = S_TKCMP;
        end
      end

      S_TKCMP: begin
        if (mem_rdata.deadline <= now_r) begin
          emit_data = mk_res(RK_WOKEN, ST_OK, mem_rdata.thread, 1'b0, 1'b0, 32'd0, 1'b0);
          if (out_free) begin
            emit_valid = 1'b1;
            head_nxt   = (head_r == IDX_W'(MAX_ENTRIES - 1)) ? '0 : head_r + 1'b1;
            count_nxt  = count_r - 1'b1;
            state_nxt  = S_TKRD;
          end
        end else begin
          emit_data = mk_res(RK_DONE, ST_OK, 16'd0, 1'b0, 1'b1,
                             mem_rdata.deadline[31:0] - now_r[31:0], 1'b1);
          if (out_free) begin
            emit_valid = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end

      S_ACK: begin
        if (out_free) begin
          emit_valid = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      head_r    <= '0;
      rd_vld_r  <= 1'b0;
      wr_pend_r <= 1'b0;
      match_r   <= 1'b0;
      gt_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      head_r    <= head_nxt;
      rd_vld_r  <= rd_vld_nxt;
      wr_pend_r <= wr_pend_nxt;
      match_r   <= match_nxt;
      gt_r      <= gt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r    <= is_ins_nxt;
    tid_r       <= tid_nxt;
    now_r       <= now_nxt;
    dl_r        <= dl_nxt;
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    rd_idx_r    <= rd_idx_nxt;
    wr_dst_r    <= wr_dst_nxt;
    match_pos_r <= match_pos_nxt;
    gt_pos_r    <= gt_pos_nxt;
    ack_r       <= ack_nxt;
  end

endmodule

// ----- src/sorted_deadline_timer_queue_unit.sv -----
// Deadline-ordered timer queue for up to MAX_ENTRIES sleeping threads. Each
// input transfer is a sleep request (kind 0), a cancel by thread ID (kind 1)
// or a tick (kind 2); kind 3 is dropped without a result. Entries live in a
// single-port-read, single-port-write store organized as a circular buffer,
// so a tick pops the head by advancing a pointer. One sequencer walks the
// store one slot per cycle, with one comparator pair checking thread ID and
// deadline, and the block takes no new transfer until the current one has
// passed all of its results to the output register. The steps per transfer:
//   sleep, nonzero amount: accept and scan, then open the slot and place
//     the entry (no shift when appended at the tail), then acknowledge; a
//     duplicate or a full queue skips the placement;
//   sleep, zero amount: accept, then acknowledge;
//   cancel: accept and scan, close the gap (no entry moves when the tail
//     entry goes, none on a miss), then acknowledge;
//   tick: accept, one result per woken thread, then the closing result.
// The store takes one read per cycle, and its read data is registered, so it
// arrives in the cycle after its address. Results wait in an output register;
// the sequencer stalls only when that register is still full. No clearing
// pass follows reset: the queue starts empty and a slot is read only after
// it has been written.
module sorted_deadline_timer_queue_unit #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sdtq_in_if.sink     in_ch,
  sdtq_out_if.source  out_ch
);
  import sdtq_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  // store port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  // result hand-off into the output register
  logic             emit_valid;
  res_t             emit_data;
  logic             out_free;

  // Sequencer: scan, shift, pop and result generation
  sdtq_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .emit_valid (emit_valid),
    .emit_data  (emit_data),
    .out_free   (out_free)
  );

  // Entry store: deadline and thread per slot
  sdtq_store #(
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: hold a result until the sink takes the transfer
  sdtq_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (emit_valid),
    .data   (emit_data),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
